// File: rtl/gsr_pkg.sv
// shared types, constants and helpers for the grid relaxation block
package gsr_pkg;

  localparam int GRID_MAX    = 62;
  localparam int VALUE_BITS  = 32;
  localparam int STORE_DEPTH = (GRID_MAX + 2) * (GRID_MAX + 2);
  localparam int ADDR_W      = 12;
  localparam int CRD_W       = $clog2(GRID_MAX + 2) + 1;
  localparam int CFG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int GATHER_N    = 6;
  localparam int STEP_W      = 3;
  localparam int SUM_W       = VALUE_BITS + 2;
  localparam int WIDE_W      = 64;
  localparam int COEF_W      = 31;

  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_SOLVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NB_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 3'd4;

  localparam logic [1:0] MODE_FLIP_X = 2'd1;
  localparam logic [1:0] MODE_FLIP_Y = 2'd2;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [ADDR_W-1:0]            cell_addr;
    logic signed [VALUE_BITS-1:0] rhs_value;
    logic signed [VALUE_BITS-1:0] start_value;
    logic                         solid_flag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               solve_done;
    logic               saturated;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDATA, S_GATHER, S_CALC, S_MUL1, S_MUL1_W, S_MUL2, S_MUL2_W, S_PUT
  } state_t;

  typedef enum logic [1:0] {
    PH_INT, PH_EDGE, PH_CRN, PH_SLD
  } phase_t;

  typedef enum logic [1:0] {
    M_IDLE, M_LO, M_HI, M_FIN
  } mul_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } mul_rsp_t;

  function automatic logic [ADDR_W-1:0] cell_at(input logic [CRD_W-1:0] x,
                                                input logic [CRD_W-1:0] y,
                                                input logic [CRD_W-1:0] w);
    logic [2*CRD_W-1:0] p;
    p = ({{CRD_W{1'b0}}, y} * {{CRD_W{1'b0}}, w}) + {{CRD_W{1'b0}}, x};
    return p[ADDR_W-1:0];
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] sat_neg(
      input logic signed [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] r;
    r = (v == VMIN) ? VMAX : -v;
    return r;
  endfunction

endpackage

// File: rtl/gsr_mul_unit.sv
// shared q16.16 multiplier: two partial products, rounding and magnitude limit
module gsr_mul_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [gsr_pkg::WIDE_W-1:0] x,
  input  logic [gsr_pkg::COEF_W-1:0]     w,
  output logic signed [gsr_pkg::WIDE_W-1:0] prod,
  output gsr_pkg::mul_rsp_t              rsp
);

  localparam logic [63:0] PROD_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic [62:0] PHI_LIMIT  = 63'h0000_4000_0000_0000;

  gsr_pkg::mul_state_t st_r, st_nxt;
  logic                          neg_r;
  logic [63:0]                   mag_r;
  logic [gsr_pkg::COEF_W-1:0]    w_r;
  logic [62:0]                   plo_r;
  logic [62:0]                   phi_r;
  logic [63:0]                   mag_in;
  logic [63:0]                   r;
  logic                          lim;

  assign mag_in = x[63] ? (64'd0 - 64'(x)) : 64'(x);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      gsr_pkg::M_IDLE: if (start) st_nxt = gsr_pkg::M_LO;
      gsr_pkg::M_LO:   st_nxt = gsr_pkg::M_HI;
      gsr_pkg::M_HI:   st_nxt = gsr_pkg::M_FIN;
      gsr_pkg::M_FIN:  st_nxt = gsr_pkg::M_IDLE;
      default:         st_nxt = gsr_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    lim = 1'b0;
    r   = '0;
    if (phi_r >= PHI_LIMIT) begin
      lim = 1'b1;
      r   = PROD_LIMIT;
    end else begin
      r = ({1'b0, phi_r} << 16) + (({1'b0, plo_r} + 64'h8000) >> 16);
      if (r > PROD_LIMIT) begin
        lim = 1'b1;
        r   = PROD_LIMIT;
      end
    end
    prod     = neg_r ? -$signed(r) : $signed(r);
    rsp.done = (st_r == gsr_pkg::M_FIN);
    rsp.sat  = (st_r == gsr_pkg::M_FIN) && lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= gsr_pkg::M_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == gsr_pkg::M_IDLE && start) begin
      neg_r <= x[63];
      mag_r <= mag_in;
      w_r   <= w;
    end
    if (st_r == gsr_pkg::M_LO) plo_r <= 63'(mag_r[31:0]) * 63'(w_r);
    if (st_r == gsr_pkg::M_HI) phi_r <= 63'(mag_r[63:32]) * 63'(w_r);
  end

endmodule

// File: rtl/gauss_seidel_grid_relaxation.sv
// grid relaxation top level: cell stores, sweep sequencer and result register
// Load items are taken while idle and write the value, rhs and solid stores at the
// transfer. A read item passes through one store read plus the result register.
// A solve item holds the block for sweep_count sweeps: every interior cell takes
// five store reads through the single read port and two passes through the one
// shared multiplier, each solid-patch visit six store reads, each edge write one
// and each corner two.
// The cell stores come up undefined; only loaded cells may be read or solved.
module gauss_seidel_grid_relaxation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gsr_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gsr_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int VB = gsr_pkg::VALUE_BITS;
  localparam int CW = gsr_pkg::CRD_W;

  // configuration
  logic [5:0]                  grid_size_r;
  logic [1:0]                  bound_mode_r;
  logic [gsr_pkg::COEF_W-1:0]  nb_weight_r;
  logic [gsr_pkg::COEF_W-1:0]  inv_center_r;
  logic [7:0]                  sweep_count_r;

  // stores
  logic signed [VB-1:0] val_mem [gsr_pkg::STORE_DEPTH];
  logic signed [VB-1:0] rhs_mem [gsr_pkg::STORE_DEPTH];
  logic                 sol_mem [gsr_pkg::STORE_DEPTH];
  logic signed [VB-1:0] val_q, rhs_q;
  logic                 sol_q;

  gsr_pkg::state_t st_r, st_nxt;
  gsr_pkg::phase_t ph_r;
  logic [CW-1:0]              ci_r, cj_r;
  logic [1:0]                 sub_r;
  logic [gsr_pkg::STEP_W-1:0] step_r;
  logic [7:0]                 sweeps_r;
  logic signed [VB-1:0]       nb_r [gsr_pkg::GATHER_N];
  logic                       sb_r [gsr_pkg::GATHER_N];
  logic signed [VB-1:0]       rhs_r;
  logic signed [gsr_pkg::SUM_W-1:0]  sum_r;
  logic signed [gsr_pkg::WIDE_W-1:0] t_r;
  logic                       sat_r;
  logic                       rd_hit_r;
  gsr_pkg::out_t              res_r;
  gsr_pkg::out_t              out_r;
  logic                       out_valid_r;

  // derived
  logic [CW-1:0]              n, n1, w;
  logic [2*CW-1:0]            cells;
  logic                       in_hit, acc, fx, fy;
  logic [CW-1:0]              gx, gy, dx, dy;
  logic [gsr_pkg::STEP_W-1:0] gcnt;
  logic [gsr_pkg::ADDR_W-1:0] rd_addr, val_wa;
  logic                       val_we, ld_we;
  logic signed [VB-1:0]       val_wd;
  logic                       sat_set;

  // advance
  gsr_pkg::phase_t ph_a;
  logic [CW-1:0]   ci_a, cj_a;
  logic [1:0]      sub_a;
  logic [7:0]      sweeps_a;
  logic            fin_a;

  // mul
  logic                              mul_start;
  logic signed [gsr_pkg::WIDE_W-1:0] mul_x, mul_p;
  logic [gsr_pkg::COEF_W-1:0]        mul_w;
  gsr_pkg::mul_rsp_t                 mul_rsp;

  gsr_mul_unit u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .w     (mul_w),
    .prod  (mul_p),
    .rsp   (mul_rsp)
  );

  assign n = (grid_size_r == 6'd0) ? CW'(1) :
             ((32'(grid_size_r) > gsr_pkg::GRID_MAX) ? CW'(gsr_pkg::GRID_MAX) :
              CW'(grid_size_r));
  assign n1     = n + CW'(1);
  assign w      = n + CW'(2);
  assign cells  = {{CW{1'b0}}, w} * {{CW{1'b0}}, w};
  assign in_hit = {{(2*CW-gsr_pkg::ADDR_W){1'b0}}, in_data.cell_addr} < cells;
  assign acc    = in_valid && in_ready;
  assign fx     = (bound_mode_r == gsr_pkg::MODE_FLIP_X);
  assign fy     = (bound_mode_r == gsr_pkg::MODE_FLIP_Y);

  assign in_ready  = (st_r == gsr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign mul_start = (st_r == gsr_pkg::S_MUL1) || (st_r == gsr_pkg::S_MUL2);
  assign mul_x     = (st_r == gsr_pkg::S_MUL1) ? gsr_pkg::WIDE_W'(sum_r) : t_r;
  assign mul_w     = (st_r == gsr_pkg::S_MUL1) ? nb_weight_r : inv_center_r;

  // gather and destination coordinates
  always_comb begin
    gx = ci_r;
    gy = cj_r;
    dx = ci_r;
    dy = cj_r;
    gcnt = 3'd1;
    unique case (ph_r)
      gsr_pkg::PH_INT: begin
        gcnt = 3'd5;
        case (step_r)
          3'd0:    gx = ci_r - CW'(1);
          3'd1:    gx = ci_r + CW'(1);
          3'd2:    gy = cj_r - CW'(1);
          3'd3:    gy = cj_r + CW'(1);
          default: ;
        endcase
      end
      gsr_pkg::PH_EDGE: begin
        gcnt = 3'd1;
        case (sub_r)
          2'd0: begin gx = CW'(1); gy = ci_r; dx = '0; dy = ci_r; end
          2'd1: begin gx = n;      gy = ci_r; dx = n1; dy = ci_r; end
          2'd2: begin gx = ci_r;   gy = CW'(1); dx = ci_r; dy = '0; end
          default: begin gx = ci_r; gy = n; dx = ci_r; dy = n1; end
        endcase
      end
      gsr_pkg::PH_CRN: begin
        gcnt = 3'd2;
        case (sub_r)
          2'd0: begin
            dx = '0; dy = '0;
            if (step_r == 3'd0) begin gx = CW'(1); gy = '0; end
            else begin gx = '0; gy = CW'(1); end
          end
          2'd1: begin
            dx = '0; dy = n1;
            if (step_r == 3'd0) begin gx = CW'(1); gy = n1; end
            else begin gx = '0; gy = n; end
          end
          2'd2: begin
            dx = n1; dy = '0;
            if (step_r == 3'd0) begin gx = n; gy = '0; end
            else begin gx = n1; gy = CW'(1); end
          end
          default: begin
            dx = n1; dy = n1;
            if (step_r == 3'd0) begin gx = n; gy = n1; end
            else begin gx = n1; gy = n; end
          end
        endcase
      end
      default: begin
        gcnt = 3'd6;
        case (step_r)
          3'd1:    gx = ci_r + CW'(1);
          3'd2:    gx = ci_r - CW'(1);
          3'd3:    gy = cj_r + CW'(1);
          3'd4:    gy = cj_r - CW'(1);
          3'd5: begin gx = ci_r - CW'(1); gy = cj_r - CW'(1); end
          default: ;
        endcase
      end
    endcase
  end

  // walk order: interior cells, edges, corners, solid patch, then next sweep
  always_comb begin
    ph_a     = ph_r;
    ci_a     = ci_r;
    cj_a     = cj_r;
    sub_a    = sub_r;
    sweeps_a = sweeps_r;
    fin_a    = 1'b0;
    unique case (ph_r)
      gsr_pkg::PH_INT, gsr_pkg::PH_SLD: begin
        if (cj_r != n) begin
          cj_a = cj_r + CW'(1);
        end else if (ci_r != n) begin
          ci_a = ci_r + CW'(1);
          cj_a = CW'(1);
        end else begin
          ci_a  = CW'(1);
          cj_a  = CW'(1);
          sub_a = '0;
          if (ph_r == gsr_pkg::PH_INT) begin
            ph_a = gsr_pkg::PH_EDGE;
          end else begin
            ph_a     = gsr_pkg::PH_INT;
            sweeps_a = sweeps_r - 8'd1;
            fin_a    = (sweeps_r == 8'd1);
          end
        end
      end
      gsr_pkg::PH_EDGE: begin
        sub_a = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          if (ci_r != n) ci_a = ci_r + CW'(1);
          else ph_a = gsr_pkg::PH_CRN;
        end
      end
      default: begin
        sub_a = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          ph_a = gsr_pkg::PH_SLD;
          ci_a = CW'(1);
          cj_a = CW'(1);
        end
      end
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      gsr_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data.kind == gsr_pkg::KIND_READ) st_nxt = gsr_pkg::S_RDATA;
          else if (in_data.kind == gsr_pkg::KIND_SOLVE)
            st_nxt = (sweep_count_r == 8'd0) ? gsr_pkg::S_PUT : gsr_pkg::S_GATHER;
        end
      end
      gsr_pkg::S_RDATA:  st_nxt = gsr_pkg::S_PUT;
      gsr_pkg::S_GATHER: if (step_r == gcnt) st_nxt = gsr_pkg::S_CALC;
      gsr_pkg::S_CALC: begin
        if (ph_r == gsr_pkg::PH_INT) st_nxt = gsr_pkg::S_MUL1;
        else st_nxt = fin_a ? gsr_pkg::S_PUT : gsr_pkg::S_GATHER;
      end
      gsr_pkg::S_MUL1:   st_nxt = gsr_pkg::S_MUL1_W;
      gsr_pkg::S_MUL1_W: if (mul_rsp.done) st_nxt = gsr_pkg::S_MUL2;
      gsr_pkg::S_MUL2:   st_nxt = gsr_pkg::S_MUL2_W;
      gsr_pkg::S_MUL2_W: if (mul_rsp.done) st_nxt = gsr_pkg::S_GATHER;
      gsr_pkg::S_PUT:    if (!out_valid_r || out_ready) st_nxt = gsr_pkg::S_IDLE;
      default:           st_nxt = gsr_pkg::S_IDLE;
    endcase
  end

  // store access and write-back values
  always_comb begin
    logic signed [VB:0] hs;
    logic signed [VB-1:0] v;
    logic flip;
    hs      = '0;
    v       = '0;
    flip    = 1'b0;
    ld_we   = (st_r == gsr_pkg::S_IDLE) && acc &&
              (in_data.kind == gsr_pkg::KIND_LOAD) && in_hit;
    rd_addr = (st_r == gsr_pkg::S_GATHER) ? gsr_pkg::cell_at(gx, gy, w) : in_data.cell_addr;
    val_we  = ld_we;
    val_wa  = ld_we ? in_data.cell_addr : gsr_pkg::cell_at(dx, dy, w);
    val_wd  = in_data.start_value;
    sat_set = 1'b0;
    if (st_r == gsr_pkg::S_MUL2_W && mul_rsp.done) begin
      val_we = 1'b1;
      if (mul_p > gsr_pkg::WIDE_W'(gsr_pkg::VMAX)) begin
        val_wd = gsr_pkg::VMAX; sat_set = 1'b1;
      end else if (mul_p < gsr_pkg::WIDE_W'(gsr_pkg::VMIN)) begin
        val_wd = gsr_pkg::VMIN; sat_set = 1'b1;
      end else begin
        val_wd = mul_p[VB-1:0];
      end
    end else if (st_r == gsr_pkg::S_CALC) begin
      unique case (ph_r)
        gsr_pkg::PH_EDGE: begin
          flip    = (sub_r[1] == 1'b0) ? fx : fy;
          val_we  = 1'b1;
          val_wd  = flip ? gsr_pkg::sat_neg(nb_r[0]) : nb_r[0];
          sat_set = flip && (nb_r[0] == gsr_pkg::VMIN);
        end
        gsr_pkg::PH_CRN: begin
          // floor of the halved sum
          hs     = (VB+1)'(nb_r[0]) + (VB+1)'(nb_r[1]);
          val_we = 1'b1;
          val_wd = hs[VB:1];
        end
        gsr_pkg::PH_SLD: begin
          if (sb_r[0]) begin
            v = '0;
            if (!sb_r[1]) v = fx ? gsr_pkg::sat_neg(nb_r[1]) : nb_r[1];
            if (!sb_r[2]) v = fx ? gsr_pkg::sat_neg(nb_r[2]) : nb_r[2];
            if (!sb_r[3]) v = fy ? gsr_pkg::sat_neg(nb_r[3]) : nb_r[3];
            if (!sb_r[4]) v = fy ? gsr_pkg::sat_neg(nb_r[4]) : nb_r[4];
            // inner corner takes the diagonal
            if (sb_r[2] && sb_r[4] && !sb_r[5]) v = nb_r[5];
            val_we  = 1'b1;
            val_wd  = v;
            sat_set = (!sb_r[1] && fx && nb_r[1] == gsr_pkg::VMIN) ||
                      (!sb_r[2] && fx && nb_r[2] == gsr_pkg::VMIN) ||
                      (!sb_r[3] && fy && nb_r[3] == gsr_pkg::VMIN) ||
                      (!sb_r[4] && fy && nb_r[4] == gsr_pkg::VMIN);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_we) rhs_mem[in_data.cell_addr] <= in_data.rhs_value;
    rhs_q <= rhs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ld_we) sol_mem[in_data.cell_addr] <= in_data.solid_flag;
    sol_q <= sol_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= gsr_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      sat_r         <= 1'b0;
      grid_size_r   <= 6'd62;
      bound_mode_r  <= 2'd0;
      nb_weight_r   <= 31'd65536;
      inv_center_r  <= 31'd16384;
      sweep_count_r <= 8'd20;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gsr_pkg::CFG_GRID_SIZE:   grid_size_r   <= cfg_data[5:0];
          gsr_pkg::CFG_BOUND_MODE:  bound_mode_r  <= cfg_data[1:0];
          gsr_pkg::CFG_NB_WEIGHT:   nb_weight_r   <= cfg_data;
          gsr_pkg::CFG_INV_CENTER:  inv_center_r  <= cfg_data;
          gsr_pkg::CFG_SWEEP_COUNT: sweep_count_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (st_r == gsr_pkg::S_IDLE && acc && in_data.kind == gsr_pkg::KIND_SOLVE)
        sat_r <= 1'b0;
      else if (sat_set || (mul_rsp.done && mul_rsp.sat))
        sat_r <= 1'b1;
      if (st_r == gsr_pkg::S_PUT && (!out_valid_r || out_ready))
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    unique case (st_r)
      gsr_pkg::S_IDLE: begin
        rd_hit_r <= in_hit;
        ph_r     <= gsr_pkg::PH_INT;
        ci_r     <= CW'(1);
        cj_r     <= CW'(1);
        sub_r    <= '0;
        step_r   <= '0;
        sweeps_r <= sweep_count_r;
        res_r    <= '{cell_value: '0, solve_done: 1'b1, saturated: 1'b0};
      end
      gsr_pkg::S_RDATA: begin
        res_r <= '{cell_value: rd_hit_r ? val_q : '0, solve_done: 1'b0, saturated: sat_r};
      end
      gsr_pkg::S_GATHER: begin
        if (step_r != '0) begin
          nb_r[step_r - 3'd1] <= val_q;
          sb_r[step_r - 3'd1] <= sol_q;
          if (step_r == 3'd5) rhs_r <= rhs_q;
        end
        step_r <= step_r + 3'd1;
      end
      gsr_pkg::S_CALC: begin
        sum_r <= gsr_pkg::SUM_W'(nb_r[0]) + gsr_pkg::SUM_W'(nb_r[1]) +
                 gsr_pkg::SUM_W'(nb_r[2]) + gsr_pkg::SUM_W'(nb_r[3]);
        step_r <= '0;
        if (ph_r != gsr_pkg::PH_INT) begin
          ph_r     <= ph_a;
          ci_r     <= ci_a;
          cj_r     <= cj_a;
          sub_r    <= sub_a;
          sweeps_r <= sweeps_a;
          res_r    <= '{cell_value: '0, solve_done: 1'b1,
                        saturated: sat_r || sat_set};
        end
      end
      gsr_pkg::S_MUL1_W: begin
        if (mul_rsp.done) t_r <= gsr_pkg::WIDE_W'(rhs_r) + mul_p;
      end
      gsr_pkg::S_MUL2_W: begin
        if (mul_rsp.done) begin
          ph_r     <= ph_a;
          ci_r     <= ci_a;
          cj_r     <= cj_a;
          sub_r    <= sub_a;
          sweeps_r <= sweeps_a;
        end
      end
      gsr_pkg::S_PUT: begin
        if (!out_valid_r || out_ready) out_r <= res_r;
      end
      default: ;
    endcase
  end

endmodule
